// File: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the small set table
// Sizes, opcode values, controller states and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

    // table geometry
    localparam int CAPACITY = 32;
    localparam int ELEM_W   = 8;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int OP_W     = 2;

    // opcodes; the unused code behaves as a lookup
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic capture_match;
        logic apply;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] count;
    } dp_status_t;

endpackage

// File: design/sst_in_if.sv
// ----------------------------------------------------------------------------
// sst_in_if: request channel of the small set table
// Valid/ready channel carrying one opcode and one element per beat.
// ----------------------------------------------------------------------------
interface sst_in_if;

    logic                        valid;
    logic                        ready;
    logic [sst_pkg::OP_W-1:0]    opcode;
    logic [sst_pkg::ELEM_W-1:0]  element;

    modport source (output valid, output opcode, output element, input ready);
    modport sink   (input valid, input opcode, input element, output ready);

endinterface

// File: design/sst_out_if.sv
// ----------------------------------------------------------------------------
// sst_out_if: response channel of the small set table
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface sst_out_if;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sst_pkg::IDX_W-1:0]  position;
    logic [sst_pkg::CNT_W-1:0]  count_after;
    logic                       full_rejected;

    modport source (output valid, output found, output position,
                    output count_after, output full_rejected, input ready);
    modport sink   (input valid, input found, input position,
                    input count_after, input full_rejected, output ready);

endinterface

// File: design/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: sequencing controller of the small set table
// Takes one request beat, lets the datapath search the table, then applies
// the update once the response register is free.
// ----------------------------------------------------------------------------
module sst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sst_pkg::dp_status_t sts,
    output sst_pkg::ctrl_cmd_t  cmd
);

    sst_pkg::state_t state_reg;
    sst_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        cmd.load_item     = 1'b0;
        cmd.capture_match = 1'b0;
        cmd.apply         = 1'b0;
        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = sst_pkg::ST_COMPARE;
                end
            end
            sst_pkg::ST_COMPARE:
            begin
                cmd.capture_match = 1'b1;
                state_next        = sst_pkg::ST_APPLY;
            end
            sst_pkg::ST_APPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/sst_datapath.sv
// ----------------------------------------------------------------------------
// sst_datapath: slot storage, search and update of the small set table
// Holds the packed slots and the count, compares all live slots in
// parallel, shifts entries down on removal and keeps the response register.
// ----------------------------------------------------------------------------
module sst_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sst_pkg::OP_W-1:0]      opcode,
    input  logic [sst_pkg::ELEM_W-1:0]    element,
    input  sst_pkg::ctrl_cmd_t            cmd,
    output sst_pkg::dp_status_t           sts,
    sst_out_if.source                     rsp
);

    logic [sst_pkg::ELEM_W-1:0] slot_reg  [sst_pkg::CAPACITY];
    logic [sst_pkg::ELEM_W-1:0] slot_next [sst_pkg::CAPACITY];

    logic [sst_pkg::OP_W-1:0]   op_reg;
    logic [sst_pkg::ELEM_W-1:0] elem_reg;
    logic                       hit_reg;
    logic [sst_pkg::IDX_W-1:0]  pos_reg;
    logic [sst_pkg::CNT_W-1:0]  count_reg;
    logic [sst_pkg::CNT_W-1:0]  count_next;

    logic                       found_reg;
    logic [sst_pkg::IDX_W-1:0]  position_reg;
    logic [sst_pkg::CNT_W-1:0]  count_after_reg;
    logic                       rejected_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic [sst_pkg::CAPACITY-1:0] match;
    logic                         hit;
    logic [sst_pkg::IDX_W-1:0]    pos;
    logic                         is_full;
    logic                         do_append;
    logic                         do_delete;
    logic                         rejected;

    // parallel compare against the live slots
    always_comb
    begin
        for (int i = 0; i < sst_pkg::CAPACITY; i++)
        begin
            match[i] = (sst_pkg::CNT_W'(i) < count_reg) && (slot_reg[i] == elem_reg);
        end
    end

    // lowest matching slot
    always_comb
    begin
        hit = |match;
        pos = '0;
        for (int i = sst_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                pos = sst_pkg::IDX_W'(i);
            end
        end
    end

    // opcode decode on the captured search result
    always_comb
    begin
        is_full   = (count_reg == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
        do_append = 1'b0;
        do_delete = 1'b0;
        rejected  = 1'b0;
        case (op_reg)
            sst_pkg::OP_INSERT:
            begin
                do_append = !hit_reg && !is_full;
                rejected  = !hit_reg && is_full;
            end
            sst_pkg::OP_REMOVE:
            begin
                do_delete = hit_reg;
            end
            default:
            begin
                do_append = 1'b0;
            end
        endcase
    end

    // slot update: append at the top or close the gap left by a removal
    always_comb
    begin
        for (int i = 0; i < sst_pkg::CAPACITY; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (cmd.apply && do_append)
        begin
            slot_next[count_reg[sst_pkg::IDX_W-1:0]] = elem_reg;
        end
        if (cmd.apply && do_delete)
        begin
            for (int i = 0; i < sst_pkg::CAPACITY - 1; i++)
            begin
                if ((sst_pkg::IDX_W'(i) >= pos_reg) &&
                    (sst_pkg::CNT_W'(i + 1) < count_reg))
                begin
                    slot_next[i] = slot_reg[i + 1];
                end
            end
        end
    end

    // count after the operation
    always_comb
    begin
        count_next = count_reg;
        if (do_append)
        begin
            count_next = count_reg + sst_pkg::CNT_W'(1);
        end
        else if (do_delete)
        begin
            count_next = count_reg - sst_pkg::CNT_W'(1);
        end
    end

    // response valid: set on apply, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sst_pkg::CAPACITY; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // request and search payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= opcode;
            elem_reg <= element;
        end
        if (cmd.capture_match)
        begin
            hit_reg <= hit;
            pos_reg <= pos;
        end
        if (cmd.apply)
        begin
            found_reg       <= hit_reg;
            position_reg    <= pos_reg;
            count_after_reg <= count_next;
            rejected_reg    <= rejected;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // status and response outputs
    assign sts.out_free      = !out_valid_reg || rsp.ready;
    assign sts.count         = count_reg;
    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.position      = position_reg;
    assign rsp.count_after   = count_after_reg;
    assign rsp.full_rejected = rejected_reg;

endmodule

// File: design/small_set_table.sv
// ----------------------------------------------------------------------------
// small_set_table: packed set of distinct bytes with insert, remove, lookup
// Steps: a request beat is loaded, compared, then applied, and the response
// is valid once the apply step registers it; no new request is taken before
// apply. A response still held by the sink stalls apply and the next request.
// Reset: rst_n clears the count and the response valid; slot contents are
// not reset and only slots below the count are ever compared.
// ----------------------------------------------------------------------------
module small_set_table
(
    input  logic      clk,
    input  logic      rst_n,
    sst_in_if.sink    req,
    sst_out_if.source rsp
);

    sst_pkg::ctrl_cmd_t  cmd;
    sst_pkg::dp_status_t sts;
    logic                ctrl_ready;

    // sequencing controller
    sst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (ctrl_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, search and response register
    sst_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .opcode  (req.opcode),
        .element (req.element),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (rsp)
    );

    assign req.ready = ctrl_ready;

    // count never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
        else $error("set count above capacity");

    // a refused insert only happens on a full set with the element absent
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.full_rejected |->
            !rsp.found && (rsp.count_after == sst_pkg::CNT_W'(sst_pkg::CAPACITY)))
        else $error("refusal on a set that is not full");

    // position reads zero when the element was absent
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.position == '0)
        else $error("position set without a match");

    // one request in flight: no second beat on the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    // a result is only loaded when the response register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> sts.out_free)
        else $error("response overwritten before it was taken");

endmodule
